>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RTL file that carries concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset masking.
`define CHK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed: clocked property violated");

// Same-cycle implication with synchronous reset masking.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: implication violated");

`endif

>>> rtl/hwr_pkg.sv
// ----------------------------------------------------------------------------
// hwr_pkg
// Types, codes and helpers for the receive window refill block.
// ----------------------------------------------------------------------------
package hwr_pkg;

  localparam int WIN_W  = 31;
  localparam int ID_W   = 31;
  localparam int SIZE_W = 24;

  typedef logic [WIN_W-1:0]  win_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [SIZE_W-1:0] size_t;

  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  localparam logic [1:0] ST_UPDATE  = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam win_t WINDOW_RESET = win_t'(65535);

  // At most two results per item; the result queue holds two items' worth.
  localparam int MAX_RES   = 2;
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [1:0] op;
    id_t        stream_id;
    size_t      data_size;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    id_t        update_stream;
    win_t       update_increment;
    logic       last;
  } rsp_item_t;

  typedef struct packed {
    logic [1:0] n_res;
    rsp_item_t  first;
    rsp_item_t  second;
  } core_res_t;

  // floor(3*s/4) without overflow.
  function automatic win_t three_quarters(win_t s);
    logic [WIN_W+1:0] t;
    t = {2'b00, s} + {1'b0, s, 1'b0};
    return t[WIN_W+1:2];
  endfunction

endpackage

>>> rtl/hwr_if.sv
// ----------------------------------------------------------------------------
// hwr_req_if / hwr_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface hwr_req_if;
  import hwr_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface hwr_rsp_if;
  import hwr_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/hwr_credit_core.sv
// ----------------------------------------------------------------------------
// hwr_credit_core
// Stream table, connection window and the per-item refill decision.
// ----------------------------------------------------------------------------
module hwr_credit_core #(
  parameter int MAX_STREAMS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  hwr_pkg::win_t      cfg_wdata,
  input  logic               go,
  input  hwr_pkg::req_item_t item,
  output hwr_pkg::core_res_t res
);
  import hwr_pkg::*;

  localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

  logic [MAX_STREAMS-1:0] slot_valid;
  id_t  slot_stream  [MAX_STREAMS];
  win_t slot_window  [MAX_STREAMS];
  win_t slot_setting [MAX_STREAMS];
  win_t default_window;
  win_t zero_window;
  win_t conn_window;

  logic             any_hit, any_free, id_zero;
  logic [IDX_W-1:0] hit_idx, free_idx, wr_idx;
  win_t             win_sel, setting_sel, size_ext, new_win;
  logic             stream_low, conn_low;
  logic             open_wr, close_hit, data_ok;
  rsp_item_t        s_res, c_res, e_res;

  always_comb begin
    id_zero  = (item.stream_id == '0);
    any_hit  = 1'b0;
    hit_idx  = '0;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = 0; i < MAX_STREAMS; i++) begin
      if (slot_valid[i] && slot_stream[i] == item.stream_id) begin
        any_hit = 1'b1;
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
    // Descending scan leaves the lowest free slot.
    for (int i = MAX_STREAMS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
    wr_idx = any_hit ? hit_idx : free_idx;

    size_ext    = {{(WIN_W - SIZE_W){1'b0}}, item.data_size};
    win_sel     = id_zero ? zero_window : slot_window[hit_idx];
    setting_sel = id_zero ? default_window : slot_setting[hit_idx];
    stream_low  = (win_sel < size_ext) ||
                  ((win_sel - size_ext) < three_quarters(setting_sel));
    conn_low    = (conn_window < size_ext) ||
                  (conn_window < three_quarters(default_window));
    new_win     = stream_low ? setting_sel : win_sel - size_ext;

    open_wr   = (item.op == OP_OPEN) && !id_zero && (any_hit || any_free);
    close_hit = (item.op == OP_CLOSE) && !id_zero && any_hit;
    data_ok   = (item.op == OP_DATA) && (id_zero || any_hit);

    s_res = '{status: ST_UPDATE, update_stream: item.stream_id,
              update_increment: setting_sel, last: !conn_low};
    c_res = '{status: ST_UPDATE, update_stream: '0,
              update_increment: setting_sel, last: 1'b1};
    e_res = '{status: ST_UNKNOWN, update_stream: item.stream_id,
              update_increment: '0, last: 1'b1};

    res.n_res  = 2'd0;
    res.first  = e_res;
    res.second = c_res;
    if (go) begin
      case (item.op)
        OP_OPEN: begin
          if (!id_zero && !any_hit && !any_free) begin
            res.n_res        = 2'd1;
            res.first.status = ST_FULL;
          end
        end
        OP_DATA: begin
          if (!data_ok) begin
            res.n_res = 2'd1;
          end else begin
            res.n_res = {1'b0, stream_low} + {1'b0, conn_low};
            res.first = stream_low ? s_res : c_res;
          end
        end
        default: begin
          res.n_res = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid     <= '0;
      default_window <= WINDOW_RESET;
      zero_window    <= WINDOW_RESET;
      conn_window    <= WINDOW_RESET;
    end else if (cfg_we) begin
      default_window <= cfg_wdata;
      zero_window    <= cfg_wdata;
      conn_window    <= cfg_wdata;
    end else if (go) begin
      if (open_wr) begin
        slot_valid[wr_idx] <= 1'b1;
      end
      if (close_hit) begin
        slot_valid[hit_idx] <= 1'b0;
      end
      if (data_ok) begin
        if (id_zero) begin
          zero_window <= new_win;
        end
        conn_window <= conn_low ? default_window : conn_window - size_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && open_wr) begin
      slot_stream[wr_idx]  <= item.stream_id;
      slot_window[wr_idx]  <= default_window;
      slot_setting[wr_idx] <= default_window;
    end else if (go && data_ok && !id_zero) begin
      slot_window[hit_idx] <= new_win;
    end
  end

endmodule

>>> rtl/hwr_result_fifo.sv
// ----------------------------------------------------------------------------
// hwr_result_fifo
// Small result queue taking up to two results a cycle, giving one.
// ----------------------------------------------------------------------------
module hwr_result_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  hwr_pkg::core_res_t          res,
  output logic [hwr_pkg::RES_CNT_W-1:0] count,
  hwr_rsp_if.source                   rsp
);
  import hwr_pkg::*;

  rsp_item_t            mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr, rd_ptr;
  logic                 pop;
  logic [RES_PTR_W-1:0] wr_ptr_next;
  logic [RES_CNT_W-1:0] count_next;

  assign pop      = rsp.valid && rsp.ready;
  assign rsp.valid = (count != '0);
  assign rsp.item  = mem[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr + RES_PTR_W'(res.n_res);
    count_next  = count + RES_CNT_W'(res.n_res) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.n_res != 2'd0) begin
      mem[wr_ptr] <= res.first;
    end
    if (res.n_res == 2'd2) begin
      mem[wr_ptr + RES_PTR_W'(1)] <= res.second;
    end
  end

endmodule

>>> rtl/http2_receive_window_refill_unit.sv
// ----------------------------------------------------------------------------
// http2_receive_window_refill_unit: stage register, credit core, then the result queue.
// Throughput: one request a cycle when no results; otherwise a request waits until the
// queue has room for its results, which the single result port frees one at a time.
// Synchronous reset empties the stream table and queue and loads all three windows with 65535.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module http2_receive_window_refill_unit #(
  parameter int MAX_STREAMS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  hwr_pkg::win_t cfg_wdata,
  hwr_req_if.sink       req,
  hwr_rsp_if.source     rsp
);
  import hwr_pkg::*;

  // A request transfer lands in the stage register. In the following cycle the
  // core looks up the stream, decides on refills, updates its windows and
  // pushes zero, one or two results into the result queue. Because state is
  // written at the same edge that retires the staged request, the next staged
  // request always sees up-to-date windows; there are no hazards to track.
  logic                 stage_valid;
  req_item_t            stage_item;
  core_res_t            core_res;
  logic [RES_CNT_W-1:0] fifo_count;
  logic                 accept;

  // Admission keeps room for the worst case: the staged request and the new
  // one may each add two results before anything drains.
  assign req.ready = (int'(fifo_count) + (stage_valid ? MAX_RES : 0) + MAX_RES)
                     <= RES_DEPTH;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item <= req.item;
    end
  end

  hwr_credit_core #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .go        (stage_valid),
    .item      (stage_item),
    .res       (core_res)
  );

  hwr_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .res   (core_res),
    .count (fifo_count),
    .rsp   (rsp)
  );

  // A request transfer is always processed in the next cycle.
  `CHK_ASSERT(a_accept_staged, clk, rst, accept |=> stage_valid)
  // The queue never holds more than a staged request can still fill.
  `CHK_IMPLY(a_queue_room, clk, rst, stage_valid, int'(fifo_count) + MAX_RES <= RES_DEPTH)
  // Error results stand alone and carry no increment.
  `CHK_IMPLY(a_err_last, clk, rst, rsp.valid && rsp.item.status != ST_UPDATE, rsp.item.last && rsp.item.update_increment == '0)

endmodule

>>> dv/tb_http2_receive_window_refill_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http2_receive_window_refill_unit
// Self-checking bench for the receive window refill block. A scoreboard
// class tracks the connection window, the zero-stream window and the stream
// table, and queues the window updates and error results that each accepted
// request should produce. Directed frames cover the window boundaries and
// the table corner cases. Random traffic then runs under several window
// settings, with bursty requests and a stalling result consumer.
// ----------------------------------------------------------------------------
module tb_http2_receive_window_refill_unit;
  import hwr_pkg::*;

  localparam int MAX_STREAMS      = 16;
  localparam int POOL_SIZE        = 20;     // more ids than slots, so the table fills
  localparam int ITEMS_PER_PHASE  = 96;
  localparam int NUM_PHASES       = 7;
  localparam int SETTLE_CYCLES    = 8;      // lets requests without results pass the stage register
  localparam longint TIMEOUT_NS   = 10_000_000;

  // Op value 3 is unused by the block and must be ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the credit state and holds the pending update queue.
  // --------------------------------------------------------------------------
  class window_scoreboard;
    win_t      setting_dflt;
    win_t      conn_win;
    win_t      zero_win;
    bit        slot_used [MAX_STREAMS];
    id_t       slot_id   [MAX_STREAMS];
    win_t      slot_win  [MAX_STREAMS];
    win_t      slot_set  [MAX_STREAMS];
    rsp_item_t expected_q [$];
    int        mismatches;

    function new();
      set_default(WINDOW_RESET);
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      mismatches = 0;
    endfunction

    // A write of the setting also reloads the connection and zero-stream windows.
    function void set_default(win_t w);
      setting_dflt = w;
      conn_win     = w;
      zero_win     = w;
    endfunction

    static function win_t refill_mark(win_t s);
      logic [WIN_W+1:0] prod;
      prod = {2'b00, s} * 33'd3;
      return prod[WIN_W+1:2];
    endfunction

    function int lookup(id_t id);
      foreach (slot_used[i])
        if (slot_used[i] && slot_id[i] == id) return i;
      return -1;
    endfunction

    function void push(logic [1:0] st, id_t sid, win_t inc);
      rsp_item_t r;
      r.status           = st;
      r.update_stream    = sid;
      r.update_increment = inc;
      r.last             = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void note_request(req_item_t it);
      int   s;
      int   n;
      bit   known;
      win_t w;
      win_t setting;
      win_t c;
      n = 0;
      case (it.op)
        OP_OPEN: begin
          if (it.stream_id != '0) begin
            s = lookup(it.stream_id);
            if (s < 0) begin
              for (int i = MAX_STREAMS - 1; i >= 0; i--)
                if (!slot_used[i]) s = i;
            end
            if (s < 0) begin
              push(ST_FULL, it.stream_id, '0);
              n = 1;
            end else begin
              slot_used[s] = 1'b1;
              slot_id[s]   = it.stream_id;
              slot_win[s]  = setting_dflt;
              slot_set[s]  = setting_dflt;
            end
          end
        end
        OP_CLOSE: begin
          if (it.stream_id != '0) begin
            s = lookup(it.stream_id);
            if (s >= 0) slot_used[s] = 1'b0;
          end
        end
        OP_DATA: begin
          known = 1'b1;
          s = -1;
          if (it.stream_id == '0) begin
            w       = zero_win;
            setting = setting_dflt;
          end else begin
            s = lookup(it.stream_id);
            if (s < 0) begin
              push(ST_UNKNOWN, it.stream_id, '0);
              n = 1;
              known = 1'b0;
            end else begin
              w       = slot_win[s];
              setting = slot_set[s];
            end
          end
          if (known) begin
            if (w < it.data_size || (w - win_t'(it.data_size)) < refill_mark(setting)) begin
              push(ST_UPDATE, it.stream_id, setting);
              n++;
              w = setting;
            end else begin
              w = w - win_t'(it.data_size);
            end
            if (s < 0) zero_win = w;
            else slot_win[s] = w;
            // The connection is judged on its window before this frame is taken off.
            c = conn_win;
            if (c < it.data_size || c < refill_mark(setting_dflt)) begin
              push(ST_UPDATE, '0, setting);
              n++;
              conn_win = setting_dflt;
            end else begin
              conn_win = c - win_t'(it.data_size);
            end
          end
        end
        default: ;
      endcase
      if (n > 0) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_result(rsp_item_t got);
      rsp_item_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result st=%0d sid=%h inc=%h last=%0b",
                         got.status, got.update_stream, got.update_increment, got.last));
      end else begin
        exp = expected_q.pop_front();
        if (got.status !== exp.status || got.update_stream !== exp.update_stream ||
            got.update_increment !== exp.update_increment || got.last !== exp.last) begin
          report($sformatf("got st=%0d sid=%h inc=%h last=%0b, want st=%0d sid=%h inc=%h last=%0b",
                           got.status, got.update_stream, got.update_increment, got.last,
                           exp.status, exp.update_stream, exp.update_increment, exp.last));
        end
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  win_t cfg_wdata;

  always #10 clk = ~clk;

  hwr_req_if req_if ();
  hwr_rsp_if rsp_if ();

  http2_receive_window_refill_unit #(
    .MAX_STREAMS(MAX_STREAMS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  window_scoreboard sb = new();

  id_t id_pool [POOL_SIZE];
  int  burst_left = 0;

  // --------------------------------------------------------------------------
  // Result consumer. Ready follows a 16-bit stall pattern that is swapped out
  // after a run of random length: sometimes always ready, sometimes sparse, so that
  // the result queue backs up and the request side sees back-pressure.
  // --------------------------------------------------------------------------
  logic [15:0] stall_pat = 16'hFFFF;
  logic [3:0]  pat_pos   = '0;
  int          pat_left  = 0;

  always @(negedge clk) begin
    if (pat_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pat = 16'hFFFF;
        1: stall_pat = 16'($urandom);
        2: stall_pat = 16'($urandom & $urandom & $urandom) | 16'h0001;
        default: stall_pat = 16'($urandom | $urandom);
      endcase
      pat_left = $urandom_range(32, 200);
    end
    pat_left--;
    rsp_if.ready <= stall_pat[pat_pos];
    pat_pos++;
  end

  // Every result transfer is checked against the oldest pending expectation.
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_result(rsp_if.item);
  end

  // --------------------------------------------------------------------------
  // Request side. Tasks are entered and left at a falling edge; inputs only
  // change there. Requests go out in bursts of random length, and valid only
  // drops when a real gap follows, so back-to-back transfers keep valid high.
  // --------------------------------------------------------------------------
  function automatic req_item_t frame_item(logic [1:0] op, id_t id, size_t size);
    req_item_t it;
    it.op        = op;
    it.stream_id = id;
    it.data_size = size;
    return it;
  endfunction

  task automatic send_item(input req_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.item  <= it;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_request(it);
    @(negedge clk);
  endtask

  // Stop sending, wait for every expected result, then let any request that
  // produces no result work its way through the pipeline.
  task automatic drain_and_settle();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The window setting is only changed while the block is idle.
  task automatic write_window(input win_t w);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    sb.set_default(w);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Ids come from a per-phase pool that is a little larger than the table,
  // so opens, closes, data on open streams and table-full errors all occur.
  // Sizes mostly fall below a quarter of the setting so that windows drain
  // over several frames; the rest go up to half of it, span the full range or are the maximum.
  function automatic req_item_t random_item();
    req_item_t   it;
    int unsigned pick;
    int unsigned quarter;
    pick = $urandom_range(0, 99);
    if (pick < 22)      it.op = OP_OPEN;
    else if (pick < 34) it.op = OP_CLOSE;
    else if (pick < 97) it.op = OP_DATA;
    else                it.op = OP_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 6)       it.stream_id = '0;
    else if (pick < 9)  it.stream_id = id_t'($urandom);
    else                it.stream_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    quarter = sb.setting_dflt >> 2;
    if (quarter > 32'h00FF_FFFF) quarter = 32'h00FF_FFFF;
    case ($urandom_range(0, 9))
      0:             it.data_size = '0;
      1, 2, 3, 4, 5: it.data_size = size_t'($urandom_range(0, quarter));
      6, 7:          it.data_size = size_t'($urandom_range(0, 2 * quarter));
      8:             it.data_size = size_t'($urandom);
      default:       it.data_size = '1;
    endcase
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    win_t      phase_window [NUM_PHASES];
    req_item_t it;
    int        counted;

    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.item  = '0;
    rsp_if.ready = 1'b0;

    // Phase 0 runs on the reset setting; the others write a new one first.
    phase_window[0] = WINDOW_RESET;
    phase_window[1] = '0;
    phase_window[2] = win_t'(1);
    phase_window[3] = '1;
    phase_window[4] = win_t'(32'h00FF_FFFF);
    phase_window[5] = win_t'($urandom_range(1024, 1 << 20));
    phase_window[6] = WINDOW_RESET;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames on the reset setting of 65535, whose refill mark is 49151.
    // Zero-sized data on stream 0 leaves both windows alone; an oversized
    // frame then refills both of them.
    send_item(frame_item(OP_DATA, '0, '0));
    send_item(frame_item(OP_DATA, '0, '1));
    // Open and close of stream 0, close of a stream never opened and the
    // unused op are all dropped silently.
    send_item(frame_item(OP_OPEN, '0, '0));
    send_item(frame_item(OP_CLOSE, '0, '0));
    send_item(frame_item(OP_CLOSE, id_t'(31'h1234), '0));
    send_item(frame_item(OP_UNUSED, '1, '1));
    // Data for a stream that is not open is an error and touches no window.
    send_item(frame_item(OP_DATA, '1, size_t'(100)));
    // Open twice; the second open simply overwrites the entry.
    send_item(frame_item(OP_OPEN, '1, '0));
    send_item(frame_item(OP_OPEN, '1, '1));
    // Land exactly on the refill mark, then one byte below it on the stream;
    // so the connection falls one byte below its mark; empty data refills it.
    send_item(frame_item(OP_DATA, '1, size_t'(16384)));
    send_item(frame_item(OP_DATA, '1, size_t'(1)));
    send_item(frame_item(OP_DATA, '1, '0));
    // Fill the table, then try one open too many.
    for (int i = 1; i < MAX_STREAMS; i++) send_item(frame_item(OP_OPEN, id_t'(i), '0));
    send_item(frame_item(OP_OPEN, id_t'(31'h4000_0000), '0));
    // A closed stream is unknown again.
    send_item(frame_item(OP_CLOSE, '1, '0));
    send_item(frame_item(OP_DATA, '1, size_t'(5)));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) write_window(phase_window[ph]);
      id_pool[0] = id_t'(1);
      id_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
        id_pool[i] = id_t'($urandom);
        if (id_pool[i] == '0) id_pool[i] = id_t'(i);
      end
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it = random_item();
        send_item(it);
        // Unused ops and opens or closes of stream 0, which the block drops without a trace, are not counted.
        if (!(it.op == OP_UNUSED || (it.op != OP_DATA && it.stream_id == '0)))
          counted++;
        // In the middle of phase 2, hold off until the result side has caught up.
        if (ph == 2 && counted == ITEMS_PER_PHASE / 2) drain_and_settle();
      end
    end

    drain_and_settle();
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hang: results that never arrive end the run as a failure.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/hwr_pkg.sv
rtl/hwr_if.sv
rtl/hwr_credit_core.sv
rtl/hwr_result_fifo.sv
rtl/http2_receive_window_refill_unit.sv
dv/tb_http2_receive_window_refill_unit.sv
